### rtl/hpr_pkg.sv
// Shared types and constants for the homography pixel remap core.
`timescale 1ns / 1ps
package hpr_pkg;

  // Configuration register map
  typedef enum logic [3:0] {
    REG_M00 = 4'd0,
    REG_M01 = 4'd1,
    REG_M02 = 4'd2,
    REG_M10 = 4'd3,
    REG_M11 = 4'd4,
    REG_M12 = 4'd5,
    REG_M20 = 4'd6,
    REG_M21 = 4'd7
  } reg_idx_e;

  localparam int unsigned NUM_REGS = 8;
  localparam int unsigned CFG_IW   = 4;
  localparam int unsigned COEF_W   = 32;

  localparam logic [COEF_W-1:0] COEF_ONE_Q20 = 32'h0010_0000;

  // Frame size defaults
  localparam int unsigned OUT_ROWS_DEF = 1024;
  localparam int unsigned OUT_COLS_DEF = 1024;
  localparam int unsigned IN_ROWS_DEF  = 4096;
  localparam int unsigned IN_COLS_DEF  = 4096;

  // Datapath widths
  localparam int unsigned PROD_W = 45;          // 32b signed x 13b signed
  localparam int unsigned ACC_W  = 47;          // X, Y, W accumulators
  localparam int unsigned NUM_W  = ACC_W + 10;  // |X * 2^10|
  localparam int unsigned QB     = 13;          // quotient bits computed
  localparam int unsigned CAND_W = ACC_W + QB;  // shifted divisor

  localparam logic signed [ACC_W-1:0] W_ONE_Q30 = 47'sd1073741824;

  // Pipeline depth in front of the output register
  localparam int unsigned FRONT_STAGES = 2;
  localparam int unsigned DIV_STAGES   = QB + 1;
  localparam int unsigned META_STAGES  = FRONT_STAGES + DIV_STAGES;

  typedef struct packed {
    logic [11:0] src_row;
    logic [11:0] src_col;
    logic [7:0]  pixel_value;
  } in_item_t;

  typedef struct packed {
    logic [9:0] dest_row;
    logic [9:0] dest_col;
    logic [7:0] out_value;
    logic       write_valid;
  } out_item_t;

  // Per-stage side band that travels with the arithmetic
  typedef struct packed {
    logic       vld;
    logic       ok;
    logic [7:0] pix;
  } meta_t;

endpackage

### rtl/hpr_front.sv
// Two-stage multiply-accumulate forming X, Y and W from the source coordinates.
`timescale 1ns / 1ps
module hpr_front (
  input  logic                                    clk_i,
  input  logic                                    en_i,
  input  logic [11:0]                             row_i,
  input  logic [11:0]                             col_i,
  input  logic [hpr_pkg::NUM_REGS-1:0][hpr_pkg::COEF_W-1:0] coef_i,
  output logic signed [hpr_pkg::ACC_W-1:0]        x_o,
  output logic signed [hpr_pkg::ACC_W-1:0]        y_o,
  output logic signed [hpr_pkg::ACC_W-1:0]        w_o
);

  logic signed [12:0]                 row_s;
  logic signed [12:0]                 col_s;
  logic signed [hpr_pkg::PROD_W-1:0]  prod_d [6];
  logic signed [hpr_pkg::PROD_W-1:0]  prod_q [6];
  logic signed [hpr_pkg::ACC_W-1:0]   x_d, y_d, w_d;
  logic signed [hpr_pkg::ACC_W-1:0]   x_q, y_q, w_q;
  logic signed [hpr_pkg::ACC_W-1:0]   tx, ty;

  assign row_s = $signed({1'b0, row_i});
  assign col_s = $signed({1'b0, col_i});

  // Stage one: six coefficient products
  always_comb begin
    prod_d[0] = $signed(coef_i[hpr_pkg::REG_M00]) * row_s;
    prod_d[1] = $signed(coef_i[hpr_pkg::REG_M01]) * col_s;
    prod_d[2] = $signed(coef_i[hpr_pkg::REG_M10]) * row_s;
    prod_d[3] = $signed(coef_i[hpr_pkg::REG_M11]) * col_s;
    prod_d[4] = $signed(coef_i[hpr_pkg::REG_M20]) * row_s;
    prod_d[5] = $signed(coef_i[hpr_pkg::REG_M21]) * col_s;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  // Stage two: sums, translations scaled from Q.16 to Q.20
  assign tx = hpr_pkg::ACC_W'($signed(coef_i[hpr_pkg::REG_M02])) <<< 4;
  assign ty = hpr_pkg::ACC_W'($signed(coef_i[hpr_pkg::REG_M12])) <<< 4;

  always_comb begin
    x_d = hpr_pkg::ACC_W'(prod_q[0]) + hpr_pkg::ACC_W'(prod_q[1]) + tx;
    y_d = hpr_pkg::ACC_W'(prod_q[2]) + hpr_pkg::ACC_W'(prod_q[3]) + ty;
    w_d = hpr_pkg::ACC_W'(prod_q[4]) + hpr_pkg::ACC_W'(prod_q[5]) + hpr_pkg::W_ONE_Q30;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      w_q <= w_d;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign w_o = w_q;

endmodule

### rtl/hpr_div.sv
// Pipelined restoring divider: truncated quotient (num * 2^10) / den, one bit a stage.
`timescale 1ns / 1ps
module hpr_div (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [hpr_pkg::ACC_W-1:0]  num_i,
  input  logic signed [hpr_pkg::ACC_W-1:0]  den_i,
  output logic [hpr_pkg::QB-1:0]            quo_o,
  output logic                              good_o
);

  localparam int unsigned NW = hpr_pkg::NUM_W;
  localparam int unsigned DW = hpr_pkg::ACC_W;
  localparam int unsigned CW = hpr_pkg::CAND_W;
  localparam int unsigned QB = hpr_pkg::QB;

  logic [NW-1:0] rem_q  [QB+1];
  logic [DW-1:0] den_q  [QB+1];
  logic [QB-1:0] quo_q  [QB+1];
  logic          good_q [QB+1];

  logic [NW-1:0] abs_n_d;
  logic [DW-1:0] abs_d_d;
  logic          good_d;
  logic signed [NW-1:0] num_x;

  // Prepare magnitudes; drop items with a non-positive or too large quotient
  always_comb begin
    num_x   = NW'(num_i) <<< 10;
    abs_n_d = num_x[NW-1] ? NW'(-num_x) : NW'(num_x);
    abs_d_d = den_i[DW-1] ? DW'(-den_i) : DW'(den_i);
    good_d  = (num_i != '0) && (den_i != '0) && (num_i[DW-1] == den_i[DW-1])
              && ({3'b000, abs_n_d} < {abs_d_d, {QB{1'b0}}});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= abs_n_d;
      den_q[0]  <= abs_d_d;
      quo_q[0]  <= '0;
      good_q[0] <= good_d;
    end
  end

  // One quotient bit a stage, most significant first
  for (genvar k = 1; k <= QB; k++) begin : g_step
    localparam int unsigned SH = QB - k;
    logic [CW-1:0] cand;
    logic          take;

    assign cand = CW'(den_q[k-1]) << SH;
    assign take = {{(CW-NW){1'b0}}, rem_q[k-1]} >= cand;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= take ? NW'({{(CW-NW){1'b0}}, rem_q[k-1]} - cand) : rem_q[k-1];
        den_q[k]  <= den_q[k-1];
        quo_q[k]  <= take ? (quo_q[k-1] | (QB'(1) << SH)) : quo_q[k-1];
        good_q[k] <= good_q[k-1];
      end
    end
  end

  assign quo_o  = quo_q[QB];
  assign good_o = good_q[QB];

endmodule

### rtl/homography_pixel_remap_core.sv
// Top level: configuration registers, pipeline control, dividers and output register.
// From input acceptance to result valid an item passes 17 register stages
// (2 MAC, 14 divide, 1 output).
// Throughput: one item per cycle; the bit-per-stage divider pipeline sets the depth.
// A stalled output holds the whole pipeline; nothing is lost or repeated.
// Reset (rst_ni low, asynchronous) empties the pipeline and loads m00 = m11 = 1.0,
// all other coefficients 0.
`timescale 1ns / 1ps
module homography_pixel_remap_core #(
  parameter int unsigned OUT_ROWS = hpr_pkg::OUT_ROWS_DEF,
  parameter int unsigned OUT_COLS = hpr_pkg::OUT_COLS_DEF,
  parameter int unsigned IN_ROWS  = hpr_pkg::IN_ROWS_DEF,
  parameter int unsigned IN_COLS  = hpr_pkg::IN_COLS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  hpr_pkg::in_item_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output hpr_pkg::out_item_t            out_data_o,
  input  logic                          cfg_we_i,
  input  logic [hpr_pkg::CFG_IW-1:0]    cfg_idx_i,
  input  logic [hpr_pkg::COEF_W-1:0]    cfg_data_i
);

  localparam int unsigned MS = hpr_pkg::META_STAGES;
  localparam int unsigned QB = hpr_pkg::QB;

  logic [hpr_pkg::NUM_REGS-1:0][hpr_pkg::COEF_W-1:0] coef_q;
  hpr_pkg::meta_t     meta_q [MS];
  hpr_pkg::meta_t     meta_d;
  hpr_pkg::out_item_t out_d, out_q;
  logic               out_vld_q;
  logic               adv;
  logic signed [hpr_pkg::ACC_W-1:0] x_s, y_s, w_s;
  logic [QB-1:0]      qx, qy;
  logic               gx, gy, ok_fin;

  // Coefficient registers; writes past the last index are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < hpr_pkg::NUM_REGS; i++) begin
        coef_q[i] <= (i == int'(hpr_pkg::REG_M00) || i == int'(hpr_pkg::REG_M11))
                     ? hpr_pkg::COEF_ONE_Q20 : '0;
      end
    end else if (cfg_we_i && (cfg_idx_i < hpr_pkg::CFG_IW'(hpr_pkg::NUM_REGS))) begin
      coef_q[cfg_idx_i[2:0]] <= cfg_data_i;
    end
  end

  // Advance the whole pipeline unless the output item is waiting
  assign adv        = !out_vld_q || out_ready_i;
  assign in_ready_o = adv;

  // Side band: valid, source range check, pixel value
  always_comb begin
    meta_d.vld = in_valid_i;
    meta_d.ok  = ({1'b0, in_data_i.src_row} < 13'(IN_ROWS))
              && ({1'b0, in_data_i.src_col} < 13'(IN_COLS));
    meta_d.pix = in_data_i.pixel_value;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MS; i++) begin
        meta_q[i] <= '0;
      end
    end else if (adv) begin
      meta_q[0] <= meta_d;
      for (int i = 1; i < MS; i++) begin
        meta_q[i] <= meta_q[i-1];
      end
    end
  end

  hpr_front u_front (
    .clk_i  (clk_i),
    .en_i   (adv),
    .row_i  (in_data_i.src_row),
    .col_i  (in_data_i.src_col),
    .coef_i (coef_q),
    .x_o    (x_s),
    .y_o    (y_s),
    .w_o    (w_s)
  );

  hpr_div u_div_row (
    .clk_i  (clk_i),
    .en_i   (adv),
    .num_i  (x_s),
    .den_i  (w_s),
    .quo_o  (qx),
    .good_o (gx)
  );

  hpr_div u_div_col (
    .clk_i  (clk_i),
    .en_i   (adv),
    .num_i  (y_s),
    .den_i  (w_s),
    .quo_o  (qy),
    .good_o (gy)
  );

  // Frame check and zeroing of rejected destinations
  always_comb begin
    ok_fin = meta_q[MS-1].ok && gx && gy
          && (qx != '0) && (qx < QB'(OUT_ROWS))
          && (qy != '0) && (qy < QB'(OUT_COLS));
    out_d.dest_row    = ok_fin ? qx[9:0] : 10'd0;
    out_d.dest_col    = ok_fin ? qy[9:0] : 10'd0;
    out_d.out_value   = meta_q[MS-1].pix;
    out_d.write_valid = ok_fin;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= meta_q[MS-1].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // Rejected items carry zero destinations
  a_zero_dest : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_q.write_valid) |-> (out_q.dest_row == '0 && out_q.dest_col == '0))
    else $error("rejected item with non-zero destination");

  // Source outside the input frame is never written
  a_src_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && meta_q[MS-1].vld && !meta_q[MS-1].ok) |=> !out_q.write_valid)
    else $error("out-of-frame source marked for write");

  // A bubble in the last stage never produces an output item
  a_bubble : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && !meta_q[MS-1].vld) |=> !out_vld_q)
    else $error("output item from an empty stage");

endmodule

### tb/sv/homography_pixel_remap_core_tb.sv
// Self-checking testbench for the homography pixel remap core.
`timescale 1ns / 1ps
module homography_pixel_remap_core_tb;

  localparam int unsigned LATENCY   = 17;
  localparam int unsigned WD_LIMIT  = 2000;
  localparam int unsigned N_RANDOM  = 650;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_ready_o;
  hpr_pkg::in_item_t          in_data_i = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  hpr_pkg::out_item_t         out_data_o;
  logic                       cfg_we_i = 1'b0;
  logic [hpr_pkg::CFG_IW-1:0] cfg_idx_i = '0;
  logic [hpr_pkg::COEF_W-1:0] cfg_data_i = '0;

  homography_pixel_remap_core i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always #4 clk_i = ~clk_i;

  // Coefficient copy and pending destinations
  logic [hpr_pkg::COEF_W-1:0] coef [hpr_pkg::NUM_REGS];
  hpr_pkg::out_item_t         pending_dest [$];
  int unsigned                errors = 0;
  int unsigned                idle_cycles = 0;
  bit                         calm = 1'b0;
  bit                         stim_done = 1'b0;

  // Map one source pixel through the homography
  function automatic hpr_pkg::out_item_t remap_pixel(hpr_pkg::in_item_t px);
    hpr_pkg::out_item_t r;
    longint             row, col, xq, yq, wq, dr, dc;
    bit                 ok;
    row = longint'(px.src_row);
    col = longint'(px.src_col);
    xq = longint'($signed(coef[hpr_pkg::REG_M00])) * row
       + longint'($signed(coef[hpr_pkg::REG_M01])) * col
       + longint'($signed(coef[hpr_pkg::REG_M02])) * 16;
    yq = longint'($signed(coef[hpr_pkg::REG_M10])) * row
       + longint'($signed(coef[hpr_pkg::REG_M11])) * col
       + longint'($signed(coef[hpr_pkg::REG_M12])) * 16;
    wq = longint'($signed(coef[hpr_pkg::REG_M20])) * row
       + longint'($signed(coef[hpr_pkg::REG_M21])) * col
       + 64'sd1073741824;
    ok = !(row >= hpr_pkg::IN_ROWS_DEF || col >= hpr_pkg::IN_COLS_DEF || wq == 0);
    dr = 0;
    dc = 0;
    if (ok) begin
      dr = (xq * 1024) / wq;
      dc = (yq * 1024) / wq;
      if (!(dr > 0 && dr < hpr_pkg::OUT_ROWS_DEF && dc > 0 && dc < hpr_pkg::OUT_COLS_DEF))
        ok = 1'b0;
    end
    if (!ok) begin
      dr = 0;
      dc = 0;
    end
    r.dest_row    = dr[9:0];
    r.dest_col    = dc[9:0];
    r.out_value   = px.pixel_value;
    r.write_valid = ok;
    return r;
  endfunction

  // Write one coefficient at the falling edge, mirror it in the copy
  task automatic write_coef(input logic [hpr_pkg::CFG_IW-1:0] idx,
                            input logic [hpr_pkg::COEF_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx < hpr_pkg::NUM_REGS) coef[idx] = val;
  endtask

  task automatic load_matrix(input logic [hpr_pkg::COEF_W-1:0] m [hpr_pkg::NUM_REGS]);
    for (int i = 0; i < hpr_pkg::NUM_REGS; i++) write_coef(hpr_pkg::CFG_IW'(i), m[i]);
  endtask

  // Send one item; the predictor runs when it is accepted
  task automatic send_pixel(input hpr_pkg::in_item_t px);
    while (!calm && $urandom_range(99) < 13) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= px;
    do @(posedge clk_i); while (!in_ready_o);
    pending_dest.push_back(remap_pixel(px));
    @(negedge clk_i);
  endtask

  // Drop valid, wait until every result is back, then let the pipe drain
  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending_dest.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 2) @(negedge clk_i);
  endtask

  function automatic hpr_pkg::in_item_t rand_pixel(int unsigned rmax, int unsigned cmax);
    hpr_pkg::in_item_t px;
    px.src_row     = 12'($urandom_range(rmax));
    px.src_col     = 12'($urandom_range(cmax));
    px.pixel_value = 8'($urandom);
    return px;
  endfunction

  // Receiver: random stalls, compare against oldest prediction
  always @(negedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(99) >= 13);
  end

  always @(posedge clk_i) begin
    hpr_pkg::out_item_t exp_item;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_dest.size() == 0) begin
        $display("%0t: unexpected result, actual %p", $realtime, out_data_o);
        errors++;
      end else begin
        exp_item = pending_dest.pop_front();
        if (out_data_o !== exp_item) begin
          $display("%0t: mismatch, expected %p, actual %p", $realtime, exp_item, out_data_o);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no accepted item on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || stim_done)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("** homography_pixel_remap_core: FAILED **");
      $finish;
    end
  end

  typedef struct {
    hpr_pkg::in_item_t  px;
    bit                 known;
    hpr_pkg::out_item_t exp_item;
  } dir_row_t;

  initial begin
    logic [hpr_pkg::COEF_W-1:0] m [hpr_pkg::NUM_REGS];
    dir_row_t                   dir_tab [$];
    int unsigned                phase_items;
    coef[hpr_pkg::REG_M00] = hpr_pkg::COEF_ONE_Q20;
    coef[hpr_pkg::REG_M01] = '0;
    coef[hpr_pkg::REG_M02] = '0;
    coef[hpr_pkg::REG_M10] = '0;
    coef[hpr_pkg::REG_M11] = hpr_pkg::COEF_ONE_Q20;
    coef[hpr_pkg::REG_M12] = '0;
    coef[hpr_pkg::REG_M20] = '0;
    coef[hpr_pkg::REG_M21] = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed rows with the reset identity matrix: easy to read off
    dir_tab = '{
      '{'{12'd0, 12'd0, 8'h00}, 1, '{10'd0, 10'd0, 8'h00, 1'b0}},
      '{'{12'd1, 12'd1, 8'hff}, 1, '{10'd1, 10'd1, 8'hff, 1'b1}},
      '{'{12'd1023, 12'd1023, 8'h5a}, 1, '{10'd1023, 10'd1023, 8'h5a, 1'b1}},
      '{'{12'd1024, 12'd5, 8'ha5}, 1, '{10'd0, 10'd0, 8'ha5, 1'b0}},
      '{'{12'd5, 12'd0, 8'h11}, 1, '{10'd0, 10'd0, 8'h11, 1'b0}},
      '{'{12'd4095, 12'd4095, 8'h80}, 1, '{10'd0, 10'd0, 8'h80, 1'b0}},
      '{'{12'd682, 12'd341, 8'h7f}, 1, '{10'd682, 10'd341, 8'h7f, 1'b1}},
      '{'{12'd2730, 12'd1365, 8'h01}, 0, '0}
    };
    calm = 1'b1;
    foreach (dir_tab[i]) begin
      send_pixel(dir_tab[i].px);
      if (dir_tab[i].known && pending_dest[$] !== dir_tab[i].exp_item) begin
        $display("%0t: table row %0d, expected %p, actual %p", $realtime, i,
                 dir_tab[i].exp_item, pending_dest[$]);
        errors++;
      end
    end
    calm = 1'b0;
    drain();

    // Zero denominator: m20 = -1.0 makes W = 0 at row 1
    m = '{32'h0010_0000, 32'h0, 32'h0, 32'h0, 32'h0010_0000, 32'h0, 32'hC000_0000, 32'h0};
    load_matrix(m);
    send_pixel('{12'd1, 12'd7, 8'h33});
    send_pixel('{12'd2, 12'd7, 8'h34});
    send_pixel('{12'd0, 12'd9, 8'h35});
    drain();
    // Unknown register index is ignored
    write_coef(4'd8, 32'hFFFF_FFFF);
    write_coef(4'd15, 32'h1234_5678);
    send_pixel('{12'd3, 12'd4, 8'h36});
    drain();

    // Extreme coefficients, including wide destinations and negative W
    m = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
          32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
    load_matrix(m);
    send_pixel('{12'd4095, 12'd0, 8'h01});
    send_pixel('{12'd0, 12'd4095, 8'h02});
    send_pixel('{12'd4095, 12'd4095, 8'h03});
    send_pixel('{12'd1, 12'd0, 8'h04});
    drain();

    // Random phases: mostly mild transforms that land in the frame, plus noise
    for (int ph = 0; ph < 13; ph++) begin
      if (ph % 4 == 3) begin
        foreach (m[i]) m[i] = $urandom;
      end else begin
        m[hpr_pkg::REG_M00] = 32'($urandom_range(32'h0018_0000, 32'h0008_0000));
        m[hpr_pkg::REG_M01] = 32'($signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000);
        m[hpr_pkg::REG_M02] = 32'($signed($urandom_range(32'h0200_0000)) - 32'sh0080_0000);
        m[hpr_pkg::REG_M10] = 32'($signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000);
        m[hpr_pkg::REG_M11] = 32'($urandom_range(32'h0018_0000, 32'h0008_0000));
        m[hpr_pkg::REG_M12] = 32'($signed($urandom_range(32'h0200_0000)) - 32'sh0080_0000);
        m[hpr_pkg::REG_M20] = 32'($signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000);
        m[hpr_pkg::REG_M21] = 32'($signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000);
      end
      load_matrix(m);
      calm = (ph == 5);
      phase_items = N_RANDOM / 13;
      for (int k = 0; k < phase_items; k++) begin
        if ($urandom_range(9) < 8) send_pixel(rand_pixel(1100, 1100));
        else send_pixel(rand_pixel(4095, 4095));
      end
      calm = 1'b0;
      drain();
    end

    stim_done = 1'b1;
    if (errors == 0 && pending_dest.size() == 0) begin
      $display("** homography_pixel_remap_core: PASSED **");
    end else begin
      $display("** homography_pixel_remap_core: FAILED **");
    end
    $finish;
  end

endmodule
